### rtl/core/lirs_pkg.sv
package lirs_pkg;

    localparam int FRAC_W      = 32;
    localparam int STEP_W      = FRAC_W + 1;
    localparam int PHASE_W     = FRAC_W + 2;
    localparam int SAMPLE_W    = 16;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = DIFF_W + FRAC_W + 1;
    localparam int MAX_RESULTS = 7;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CFG_DATA_W  = STEP_W;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_STEP,
        CFG_MONO_SOURCE
    } cfg_index_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EVAL,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prev_left;
        logic signed [SAMPLE_W-1:0] prev_right;
        logic signed [SAMPLE_W-1:0] cur_left;
        logic signed [SAMPLE_W-1:0] cur_right;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

### rtl/core/lirs_queue.sv
module lirs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  logic                 push,
    input  lirs_pkg::job_t       push_job,
    input  logic                 pop,
    output lirs_pkg::job_t       head_job,
    output lirs_pkg::queue_stat_t stat
);
    import lirs_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign stat.full  = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

### rtl/core/lirs_front.sv
module lirs_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   clear,
    input  logic                                   mono_source,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0]   s_left_sample,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0]   s_right_sample,
    input  lirs_pkg::queue_stat_t                  q_stat,
    output logic                                   push,
    output lirs_pkg::job_t                         push_job
);
    import lirs_pkg::*;

    logic signed [SAMPLE_W-1:0] prev_left_reg;
    logic signed [SAMPLE_W-1:0] prev_right_reg;
    logic                       have_prev_reg;
    logic signed [SAMPLE_W-1:0] cur_right;
    logic                       accept;

    assign s_ready   = !q_stat.full;
    assign accept    = s_valid && s_ready;
    assign cur_right = mono_source ? s_left_sample : s_right_sample;

    // The first item after reset or a configuration write only loads the history.
    assign push                = accept && have_prev_reg;
    assign push_job.prev_left  = prev_left_reg;
    assign push_job.prev_right = prev_right_reg;
    assign push_job.cur_left   = s_left_sample;
    assign push_job.cur_right  = cur_right;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            have_prev_reg  <= 1'b0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
        end else if (accept) begin
            have_prev_reg  <= 1'b1;
            prev_left_reg  <= s_left_sample;
            prev_right_reg <= cur_right;
        end
    end

endmodule

### rtl/core/lirs_back.sv
module lirs_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   clear,
    input  logic [lirs_pkg::STEP_W-1:0]            rate_step,
    input  lirs_pkg::queue_stat_t                  q_stat,
    input  lirs_pkg::job_t                         head_job,
    output logic                                   pop,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [lirs_pkg::SAMPLE_W-1:0]   m_left_out,
    output logic signed [lirs_pkg::SAMPLE_W-1:0]   m_right_out,
    output logic                                   m_run_last
);
    import lirs_pkg::*;

    localparam int SUM_W = DIFF_W + 2;

    back_state_t                state_reg, state_next;
    logic [PHASE_W-1:0]         phase_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [SAMPLE_W-1:0] s0_left_reg, s0_right_reg;
    logic signed [DIFF_W-1:0]   diff_left_reg, diff_right_reg;
    logic signed [PROD_W-1:0]   prod_left_reg, prod_right_reg;
    logic                       last_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_left_reg, m_right_reg;
    logic                       m_last_reg;

    logic                       below_one;
    logic                       emit;
    logic                       out_free;
    logic [PHASE_W-1:0]         phase_stepped;
    logic signed [FRAC_W:0]     frac_s;
    logic                       do_load, do_emit, do_close, do_out;

    function automatic logic signed [SAMPLE_W-1:0] interp(
        input logic signed [SAMPLE_W-1:0] s0,
        input logic signed [PROD_W-1:0]   prod
    );
        logic signed [SUM_W-1:0] sum;
        sum = SUM_W'(s0) + SUM_W'($signed(prod[PROD_W-1:FRAC_W]));
        if (sum > SUM_W'(32767)) begin
            return SAMPLE_W'(32767);
        end else if (sum < -SUM_W'(32768)) begin
            return SAMPLE_W'(-32768);
        end
        return sum[SAMPLE_W-1:0];
    endfunction

    assign below_one     = (phase_reg[PHASE_W-1:FRAC_W] == '0);
    assign emit          = below_one && (cnt_reg != CNT_W'(MAX_RESULTS));
    assign out_free      = !m_valid_reg || m_ready;
    assign phase_stepped = phase_reg + PHASE_W'(rate_step);
    assign frac_s        = {1'b0, phase_reg[FRAC_W-1:0]};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = BK_EVAL;
                end
            end
            BK_EVAL: begin
                state_next = emit ? BK_OUT : BK_IDLE;
            end
            BK_OUT: begin
                if (out_free) begin
                    state_next = BK_EVAL;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        do_load  = 1'b0;
        do_emit  = 1'b0;
        do_close = 1'b0;
        do_out   = 1'b0;
        case (state_reg)
            BK_IDLE: do_load  = !q_stat.empty;
            BK_EVAL: begin
                do_emit  = emit;
                do_close = !emit;
            end
            BK_OUT:  do_out   = out_free;
            default: ;
        endcase
    end

    assign pop = do_load;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            state_reg   <= BK_IDLE;
            phase_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (do_load) begin
                cnt_reg <= '0;
            end
            if (do_emit) begin
                cnt_reg   <= cnt_reg + 1'b1;
                phase_reg <= phase_stepped;
            end
            // After the run the phase moves back by one source period, or restarts
            // at zero when the result limit cut the run short.
            if (do_close) begin
                phase_reg <= below_one ? '0 : phase_reg - (PHASE_W'(1) << FRAC_W);
            end
            if (do_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            s0_left_reg    <= head_job.prev_left;
            s0_right_reg   <= head_job.prev_right;
            diff_left_reg  <= DIFF_W'(head_job.cur_left) - DIFF_W'(head_job.prev_left);
            diff_right_reg <= DIFF_W'(head_job.cur_right) - DIFF_W'(head_job.prev_right);
        end
        if (do_emit) begin
            prod_left_reg  <= PROD_W'(diff_left_reg) * PROD_W'(frac_s);
            prod_right_reg <= PROD_W'(diff_right_reg) * PROD_W'(frac_s);
            last_reg       <= (phase_stepped[PHASE_W-1:FRAC_W] != '0)
                              || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
        end
        if (do_out) begin
            m_left_reg  <= interp(s0_left_reg, prod_left_reg);
            m_right_reg <= interp(s0_right_reg, prod_right_reg);
            m_last_reg  <= last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;
    assign m_run_last  = m_last_reg;

endmodule

### rtl/core/linear_interp_resampler_stereo_unit.sv
// Linear-interpolation resampler for stereo audio. Each source frame is queued (two
// deep) for the interpolation engine, which loads a frame, then for each of its n
// results (n at most 7) evaluates and outputs it with its one pair of multipliers,
// one result at a time, and finally closes the run; a stalled output holds it waiting.
// The first frame after reset or after any configuration write yields no result, and
// every configuration write clears the phase and the sample history.
module linear_interp_resampler_stereo_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [lirs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lirs_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0]   s_left_sample,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0]   s_right_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [lirs_pkg::SAMPLE_W-1:0]   m_left_out,
    output logic signed [lirs_pkg::SAMPLE_W-1:0]   m_right_out,
    output logic                                   m_run_last
);
    import lirs_pkg::*;

    logic [STEP_W-1:0] rate_step_reg;
    logic              mono_source_reg;
    logic              clear;
    queue_stat_t       q_stat;
    logic              push, pop;
    job_t              push_job, head_job;

    assign clear = cfg_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_step_reg   <= STEP_RESET;
            mono_source_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_RATE_STEP:   rate_step_reg   <= cfg_data;
                CFG_MONO_SOURCE: mono_source_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    lirs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .clear          (clear),
        .mono_source    (mono_source_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .q_stat         (q_stat),
        .push           (push),
        .push_job       (push_job)
    );

    lirs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (clear),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    lirs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (clear),
        .rate_step   (rate_step_reg),
        .q_stat      (q_stat),
        .head_job    (head_job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out),
        .m_run_last  (m_run_last)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_clear_empties_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> q_stat.empty && !m_valid)
        else $error("configuration write left work pending");

endmodule
